[hw/rtl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator: request and
// result transaction layouts, operation, status and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned DefPoolDepth    = 256;
  localparam int unsigned DefAddressWidth = 32;

  // Fixed field widths of the transactions and registers
  localparam int unsigned AddrFieldW  = 32;
  localparam int unsigned CountFieldW = 9;
  localparam int unsigned SizeFieldW  = 17;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 32;

  // Register reset values and the minimum block size
  localparam logic [AddrFieldW-1:0]  BaseAddressReset = '0;
  localparam logic [SizeFieldW-1:0]  BlockSizeReset   = 17'd64;
  localparam logic [CountFieldW-1:0] BlockCountReset  = 9'd256;
  localparam logic [SizeFieldW-1:0]  MinBlockSize     = 17'd8;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NULL_FREE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_BLOCK_SIZE   = 2'd1,
    CFG_BLOCK_COUNT  = 2'd2
  } cfg_index_e;

  // Request transaction
  typedef struct packed {
    logic [1:0]            operation;
    logic [AddrFieldW-1:0] free_address;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [AddrFieldW-1:0]  address;
    status_e                status;
    logic [CountFieldW-1:0] free_count;
  } result_t;

  // Free list control from the allocator to the stack
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_ctrl_t;

endpackage : fbpa_pkg

`default_nettype wire

[hw/rtl/fbpa_stack.sv]
// ----------------------------------------------------------------------------
// fbpa_stack
// LIFO free list of block addresses. Entries live in a one-write, one-read
// memory; the top entry is held in a register and the entry below it is
// prefetched every cycle, so pops and pushes can follow each other back to
// back without a read bubble.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_stack #(
  parameter int unsigned PoolDepth    = fbpa_pkg::DefPoolDepth,
  parameter int unsigned AddressWidth = fbpa_pkg::DefAddressWidth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fbpa_pkg::stack_ctrl_t             ctrl_i,
  input  wire logic [AddressWidth-1:0]           push_data_i,
  output logic [$clog2(PoolDepth+1)-1:0]         level_o,
  output logic [AddressWidth-1:0]                top_o
);
  import fbpa_pkg::*;

  localparam int unsigned CountW = $clog2(PoolDepth + 1);
  localparam int unsigned IndexW = $clog2(PoolDepth);

  logic [AddressWidth-1:0] mem_q [PoolDepth];
  logic [CountW-1:0]       level_q, level_d;
  logic [AddressWidth-1:0] top_q, top_d;
  logic [AddressWidth-1:0] rd_data_q;
  logic [IndexW-1:0]       rd_idx;
  logic [IndexW-1:0]       wr_idx;

  // Level update
  always_comb begin
    level_d = level_q;
    if (ctrl_i.clear) begin
      level_d = '0;
    end else if (ctrl_i.push) begin
      level_d = level_q + CountW'(1);
    end else if (ctrl_i.pop) begin
      level_d = level_q - CountW'(1);
    end
  end

  // Top register: pushed data, or the prefetched entry below on a pop
  always_comb begin
    top_d = top_q;
    if (ctrl_i.push) begin
      top_d = push_data_i;
    end else if (ctrl_i.pop) begin
      top_d = rd_data_q;
    end
  end

  // Prefetch the entry under the next top; never collides with the write slot
  assign rd_idx = IndexW'(level_d - CountW'(2));
  assign wr_idx = level_q[IndexW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_idx] <= push_data_i;
    end
    rd_data_q <= mem_q[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  assign level_o = level_q;
  assign top_o   = top_q;

endmodule : fbpa_stack

`default_nettype wire

[hw/rtl/fixed_block_pool_allocator_top.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool with a LIFO free list and a lazy untouched-block
// counter. Allocate, free and pool reset, one result per request.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   request  | in        | start_i, busy_o         | req_i (operation, address)
//   result   | out       | done_o strobe           | result_o
//   config   | in        | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// A request is taken in any cycle; its result shows on result_o with done_o
// in the cycle after acceptance, so one transaction per cycle sustained.
// The critical path is the block address multiply and add before result_q.
// busy_o stays low and cfg_ready_o stays high; there is no clearing pass,
// reset makes all blocks free at once through the untouched counter.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_top #(
  parameter int unsigned PoolDepth    = fbpa_pkg::DefPoolDepth,
  parameter int unsigned AddressWidth = fbpa_pkg::DefAddressWidth
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire fbpa_pkg::req_t                      req_i,
  // result
  output logic                                     done_o,
  output fbpa_pkg::result_t                        result_o,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [fbpa_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  wire logic [fbpa_pkg::CfgDataW-1:0]       cfg_data_i
);
  import fbpa_pkg::*;

  localparam int unsigned CountW = $clog2(PoolDepth + 1);
  localparam int unsigned ProdW  = CountW + SizeFieldW;
  localparam logic [CountW-1:0] DepthCount = CountW'(PoolDepth);

  // Configuration registers
  logic [AddrFieldW-1:0]  base_address_q;
  logic [SizeFieldW-1:0]  block_size_q;
  logic [CountFieldW-1:0] block_count_q;

  // Pool state
  logic [CountW-1:0] untouched_q, untouched_d;
  logic [CountW-1:0] free_total_q, free_total_d;
  logic [CountW-1:0] reset_count;

  // Free list
  stack_ctrl_t             stack_ctrl;
  logic [CountW-1:0]       level;
  logic [AddressWidth-1:0] stack_top;
  logic [AddressWidth-1:0] push_data;

  // Result path
  logic      accept;
  logic      done_q;
  result_t   result_q, result_d;

  // Untouched block address
  logic [SizeFieldW-1:0]   size_eff;
  logic [CountW-1:0]       blk_index;
  logic [ProdW-1:0]        blk_offset;
  logic [AddressWidth-1:0] blk_addr;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= BaseAddressReset;
      block_size_q   <= BlockSizeReset;
      block_count_q  <= BlockCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS: base_address_q <= cfg_data_i[AddrFieldW-1:0];
        CFG_BLOCK_SIZE:   block_size_q   <= cfg_data_i[SizeFieldW-1:0];
        CFG_BLOCK_COUNT:  block_count_q  <= cfg_data_i[CountFieldW-1:0];
        default: ;
      endcase
    end
  end

  // Pool reset count: block count clamped to the store depth
  always_comb begin
    if (32'(block_count_q) > 32'(PoolDepth)) begin
      reset_count = DepthCount;
    end else begin
      reset_count = CountW'(block_count_q);
    end
  end

  // Address of the highest untouched block: base + (untouched - 1) * size, size at least MinBlockSize
  assign size_eff   = (block_size_q < MinBlockSize) ? MinBlockSize : block_size_q;
  assign blk_index  = untouched_q - CountW'(1);
  assign blk_offset = ProdW'(blk_index) * ProdW'(size_eff);
  assign blk_addr   = AddressWidth'(base_address_q) + AddressWidth'(blk_offset);

  assign push_data = AddressWidth'(req_i.free_address);

  // Request decode and state update
  always_comb begin
    stack_ctrl          = '0;
    untouched_d         = untouched_q;
    free_total_d        = free_total_q;
    result_d.address    = '0;
    result_d.status     = ST_OK;
    if (accept) begin
      unique case (req_i.operation)
        OP_ALLOC: begin
          if (level != '0) begin
            stack_ctrl.pop   = 1'b1;
            result_d.address = AddrFieldW'(stack_top);
            free_total_d     = free_total_q - CountW'(1);
          end else if (untouched_q != '0) begin
            untouched_d      = untouched_q - CountW'(1);
            result_d.address = AddrFieldW'(blk_addr);
            free_total_d     = free_total_q - CountW'(1);
          end else begin
            result_d.status  = ST_EXHAUSTED;
          end
        end
        OP_FREE: begin
          if (req_i.free_address == '0) begin
            result_d.status = ST_NULL_FREE;
          end else if (free_total_q >= DepthCount || level >= DepthCount) begin
            result_d.status = ST_FULL;
          end else begin
            stack_ctrl.push = 1'b1;
            free_total_d    = free_total_q + CountW'(1);
          end
        end
        OP_RESET: begin
          stack_ctrl.clear = 1'b1;
          untouched_d      = reset_count;
          free_total_d     = reset_count;
        end
        default: ;
      endcase
    end
    result_d.free_count = CountFieldW'(free_total_d);
  end

  // Pool counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      untouched_q  <= CountW'(32'(BlockCountReset) > 32'(PoolDepth) ?
                              32'(PoolDepth) : 32'(BlockCountReset));
      free_total_q <= CountW'(32'(BlockCountReset) > 32'(PoolDepth) ?
                              32'(PoolDepth) : 32'(BlockCountReset));
      done_q       <= 1'b0;
    end else begin
      untouched_q  <= untouched_d;
      free_total_q <= free_total_d;
      done_q       <= accept;
    end
  end

  // Result register, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  fbpa_stack #(
    .PoolDepth   (PoolDepth),
    .AddressWidth(AddressWidth)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (stack_ctrl),
    .push_data_i(push_data),
    .level_o    (level),
    .top_o      (stack_top)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule : fixed_block_pool_allocator_top

`default_nettype wire
